// ----- design/spcm_pkg.sv -----
package spcm_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    REG_MOTION_EN     = 3'd0,
    REG_GAIN_P        = 3'd1,
    REG_GAIN_I        = 3'd2,
    REG_GAIN_D        = 3'd3,
    REG_NOMINAL_SPEED = 3'd4
  } reg_index_t;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // Field widths, Q4.12
  localparam int unsigned ErrW   = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned SpeedW = 15;
  localparam int unsigned TurnW  = 16;
  localparam int unsigned IntegW = 32;

  // Register reset values
  localparam logic [GainW-1:0]  GainPReset   = 16'd6144;  // 1.5
  localparam logic [GainW-1:0]  GainIReset   = 16'd0;
  localparam logic [GainW-1:0]  GainDReset   = 16'd2048;  // 0.5
  localparam logic [SpeedW-1:0] NominalReset = 15'd4915;  // 1.2 m/s

  // Thresholds and fixed values
  localparam logic [16:0]        SmallErr    = 17'd409;   // 0.1 rad
  localparam logic [16:0]        LargeErr    = 17'd4289;  // 60 deg
  localparam logic [15:0]        WeakTurn    = 16'd1228;  // 0.3 rad/s
  localparam logic signed [15:0] EscapeTurn  = -16'sd3686; // -0.9 rad/s
  localparam logic [10:0]        ScaleLarge  = 11'd1638;  // 0.4
  localparam logic [10:0]        ScaleColl   = 11'd410;   // 0.1
  localparam logic [11:0]        HalfLsb     = 12'd2048;

endpackage

// ----- design/steering_pid_with_collision_mode_unit.sv -----
// A beat accepted into s0 passes through s1 and s2 into the result register behind out_valid.
// Throughput: one beat per cycle while out_ready holds; the chain is four register stages with a ready ripple.
// Ticks taken while powered without scan data are consumed and give no result.
// Reset (rst, synchronous, active high): pipeline empty, PID state zero, registers at their
// documented defaults (power off, gain_p 1.5, gain_i 0, gain_d 0.5, speed 1.2 m/s).
module steering_pid_with_collision_mode_unit (
  input  logic                                      clk,
  input  logic                                      rst,
  // configuration writes
  input  logic                                      cfg_we,
  input  logic [spcm_pkg::CfgIndexW-1:0]            cfg_index,
  input  logic [spcm_pkg::CfgDataW-1:0]             cfg_data,
  // input beats
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [spcm_pkg::ErrW-1:0]          heading_error,
  input  logic                                      front_blocked,
  input  logic                                      all_blocked,
  input  logic                                      scan_ready,
  // result beats
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [spcm_pkg::SpeedW-1:0]               linear_speed,
  output logic signed [spcm_pkg::TurnW-1:0]         turn_rate
);
  import spcm_pkg::*;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic              motion_en;
  logic [GainW-1:0]  gain_p;
  logic [GainW-1:0]  gain_i;
  logic [GainW-1:0]  gain_d;
  logic [SpeedW-1:0] nominal_speed;

  // ------------------------------------------------------------------
  // PID state. The collision mode only ever matters while powered, and
  // then it always equals the front flag of the same tick, so the stage-1
  // front flag serves as the mode directly.
  // ------------------------------------------------------------------
  logic signed [ErrW-1:0]   last_error;
  logic signed [IntegW-1:0] error_integral;

  // ------------------------------------------------------------------
  // Pipeline registers
  // s0: captured input beat
  // s1: updated integral, error step, speed scale choice
  // s2: the three gain products and the scaled speed
  // s3: result register (out_valid, linear_speed, turn_rate)
  // ------------------------------------------------------------------
  logic                     s0_valid;
  logic signed [ErrW-1:0]   s0_err;
  logic                     s0_front;
  logic                     s0_nofree;

  logic                     s1_valid;
  logic signed [ErrW-1:0]   s1_err;
  logic signed [IntegW-1:0] s1_integral;
  logic signed [ErrW:0]     s1_delta;
  logic                     s1_large;
  logic                     s1_front;
  logic                     s1_nofree;

  logic                     s2_valid;
  logic signed [32:0]       s2_prod_p;
  logic signed [48:0]       s2_prod_i;
  logic signed [33:0]       s2_prod_d;
  logic [SpeedW-1:0]        s2_speed;
  logic                     s2_nofree;

  // Ready ripple: a stage may load when it is empty or its content moves on
  logic s1_ready, s2_ready, s3_ready;
  logic s0_adv, s1_adv, s2_adv;

  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = !s0_valid || s1_ready;
  assign s0_adv   = s0_valid && s1_ready;
  assign s1_adv   = s1_valid && s2_ready;
  assign s2_adv   = s2_valid && s3_ready;

  // ------------------------------------------------------------------
  // Stage 0 -> 1: integral update, anti-windup, error step
  // ------------------------------------------------------------------
  logic signed [ErrW:0]     e0_ext;
  logic [ErrW:0]            abs_e0;
  logic signed [IntegW:0]   integ_sum;
  logic signed [IntegW-1:0] integ_sat;
  logic signed [IntegW-1:0] integral_next;
  logic                     sign_flip;
  logic signed [ErrW:0]     delta_next;

  always_comb begin
    e0_ext = (ErrW+1)'(s0_err);
    abs_e0 = e0_ext[ErrW] ? unsigned'(-e0_ext) : unsigned'(e0_ext);

    integ_sum = (IntegW+1)'(error_integral) + (IntegW+1)'(s0_err);
    // overflow when the two top bits of the widened sum disagree
    if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
      integ_sat = integ_sum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                    : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[IntegW-1:0];
    end

    // error changed sign strictly: both values non-zero and signs differ
    sign_flip = (last_error != '0) && (s0_err != '0) && (last_error[ErrW-1] != s0_err[ErrW-1]);

    if (abs_e0 <= SmallErr || sign_flip) begin
      integral_next = '0;
    end else begin
      integral_next = integ_sat;
    end

    delta_next = e0_ext - (ErrW+1)'(last_error);
  end

  // ------------------------------------------------------------------
  // Stage 1 -> 2: gain products and speed scaling
  // ------------------------------------------------------------------
  logic signed [32:0] prod_p_c;
  logic signed [48:0] prod_i_c;
  logic signed [33:0] prod_d_c;
  logic [10:0]        scale_k;
  logic [25:0]        speed_prod;
  logic [SpeedW-1:0]  speed_c;

  always_comb begin
    prod_p_c = 33'($signed({1'b0, gain_p})) * 33'(s1_err);
    prod_i_c = 49'($signed({1'b0, gain_i})) * 49'(s1_integral);
    prod_d_c = 34'($signed({1'b0, gain_d})) * 34'(s1_delta);

    scale_k    = s1_front ? ScaleColl : ScaleLarge;
    speed_prod = 26'(nominal_speed) * 26'(scale_k) + 26'(HalfLsb);
    // collision mode always scales; normal mode only for a large error
    if (s1_front || s1_large) begin
      speed_c = {1'b0, speed_prod[25:12]};
    end else begin
      speed_c = nominal_speed;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2 -> 3: sum, round half up, saturate, zero when unpowered, no-free-space escape
  // ------------------------------------------------------------------
  logic signed [49:0]      acc;
  logic signed [37:0]      w_full;
  logic signed [TurnW-1:0] w_sat;
  logic [TurnW-1:0]        abs_w;
  logic signed [TurnW-1:0] turn_c;
  logic [SpeedW-1:0]       lin_c;

  always_comb begin
    acc    = 50'(s2_prod_p) + 50'(s2_prod_i) + 50'(s2_prod_d) + 50'(HalfLsb);
    w_full = 38'(acc >>> 12);  // arithmetic shift is a floor division
    if (w_full > 38'sd32767) begin
      w_sat = 16'sd32767;
    end else if (w_full < -38'sd32768) begin
      w_sat = -16'sd32768;
    end else begin
      w_sat = w_full[TurnW-1:0];
    end
    // -32768 wraps to itself here, which is still above the weak limit
    abs_w = w_sat[TurnW-1] ? unsigned'(-w_sat) : unsigned'(w_sat);

    lin_c  = s2_speed;
    turn_c = w_sat;
    if (s2_nofree) begin
      lin_c = '0;
      if (abs_w <= WeakTurn) begin
        turn_c = EscapeTurn;
      end
    end
    if (!motion_en) begin
      lin_c  = '0;
      turn_c = '0;
    end
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_en      <= 1'b0;
      gain_p         <= GainPReset;
      gain_i         <= GainIReset;
      gain_d         <= GainDReset;
      nominal_speed  <= NominalReset;
      last_error     <= '0;
      error_integral <= '0;
      s0_valid       <= 1'b0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MOTION_EN:     motion_en     <= cfg_data[0];
          REG_GAIN_P:        gain_p        <= cfg_data[GainW-1:0];
          REG_GAIN_I:        gain_i        <= cfg_data[GainW-1:0];
          REG_GAIN_D:        gain_d        <= cfg_data[GainW-1:0];
          REG_NOMINAL_SPEED: nominal_speed <= cfg_data[SpeedW-1:0];
          default: ;
        endcase
      end

      // a powered tick without scan data is taken and dropped here
      if (in_ready) begin
        s0_valid <= in_valid && !(motion_en && !scan_ready);
      end
      if (s1_ready) begin
        s1_valid <= s0_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        out_valid <= s2_valid;
      end

      // PID state moves with the beat leaving stage 0
      if (s0_adv) begin
        last_error     <= s0_err;
        error_integral <= integral_next;
      end
    end

    if (in_valid && in_ready) begin
      s0_err    <= heading_error;
      s0_front  <= front_blocked;
      s0_nofree <= all_blocked;
    end
    if (s0_adv) begin
      s1_err      <= s0_err;
      s1_integral <= integral_next;
      s1_delta    <= delta_next;
      s1_large    <= abs_e0 > LargeErr;
      s1_front    <= s0_front;
      s1_nofree   <= s0_nofree;
    end
    if (s1_adv) begin
      s2_prod_p <= prod_p_c;
      s2_prod_i <= prod_i_c;
      s2_prod_d <= prod_d_c;
      s2_speed  <= speed_c;
      s2_nofree <= s1_nofree;
    end
    if (s2_adv) begin
      linear_speed <= lin_c;
      turn_rate    <= turn_c;
    end
  end

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  logic [ErrW:0] abs_last;
  assign abs_last = last_error[ErrW-1] ? unsigned'(-((ErrW+1)'(last_error)))
                                       : unsigned'((ErrW+1)'(last_error));

  // unpowered results carry no motion
  a_power_off_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !motion_en) |-> (linear_speed == '0 && turn_rate == '0))
    else $error("motion output while power is off");

  // speed is only ever scaled down from nominal
  a_speed_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (linear_speed <= nominal_speed))
    else $error("linear speed above nominal");

  // a small last error always leaves the integral cleared
  a_integral_cleared: assert property (@(posedge clk) disable iff (rst)
    (error_integral != '0) |-> (abs_last > SmallErr))
    else $error("integral held with small error");

  // the PID state only changes when a beat leaves stage 0
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s0_adv |=> ($stable(last_error) && $stable(error_integral)))
    else $error("PID state changed without a beat");

endmodule

// ----- verif/tb_steering_pid_with_collision_mode_unit.sv -----
`timescale 1ns / 100ps

module tb_steering_pid_with_collision_mode_unit;
  import spcm_pkg::*;

  // Watchdog limit: cycles with no beat on either channel. The worst honest
  // wait is the longest stall plus the longest gap plus the pipeline depth.
  localparam int IdleLimit    = 2000;
  // Cycles allowed after the last result before the block is taken as idle.
  localparam int SettleCycles = 8;
  localparam int ClkHalf      = 4;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_we    = 1'b0;
  logic [CfgIndexW-1:0]          cfg_index = '0;
  logic [CfgDataW-1:0]           cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [ErrW-1:0]        heading_error = '0;
  logic                          front_blocked = 1'b0;
  logic                          all_blocked   = 1'b0;
  logic                          scan_ready    = 1'b0;
  logic                          out_valid;
  logic                          out_ready     = 1'b0;
  logic [SpeedW-1:0]             linear_speed;
  logic signed [TurnW-1:0]       turn_rate;

  always #(ClkHalf) clk = ~clk;

  steering_pid_with_collision_mode_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .heading_error (heading_error),
    .front_blocked (front_blocked),
    .all_blocked   (all_blocked),
    .scan_ready    (scan_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .linear_speed  (linear_speed),
    .turn_rate     (turn_rate)
  );

  // --------------------------------------------------------------------------
  // Controller shadow: registers and PID state as the block should hold them
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [TurnW-1:0]  turn;
  } motion_cmd_t;

  motion_cmd_t pending_cmds[$];   // motion commands still owed by the block

  logic                    shadow_power;
  logic [GainW-1:0]        shadow_kp, shadow_ki, shadow_kd;
  logic [SpeedW-1:0]       shadow_vnom;
  logic                    shadow_collision;
  logic signed [ErrW-1:0]  shadow_prev_err;
  int                      shadow_integral;   // signed 32, saturating

  int n_errors  = 0;
  int n_ticks   = 0;
  int n_skipped = 0;
  int n_checked = 0;
  int n_writes  = 0;

  // Idling profile, in percent: gaps per input beat, stalls per out_ready draw; changed per test
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    n_errors++;
  endtask

  // One control tick through the controller; queues the command it yields
  task automatic predict_motion(input logic signed [ErrW-1:0] err, input logic front,
                                input logic nofree, input logic ready);
    longint      e, mag, sum, acc, w;
    int unsigned v;
    motion_cmd_t cmd;
    e   = err;
    mag = (e < 0) ? -e : e;
    // powered but no scan yet: tick swallowed, nothing moves
    if (shadow_power && !ready) begin
      n_skipped++;
      return;
    end
    if (shadow_power) shadow_collision = front;

    // integral: cleared on small error, else saturating accumulate
    if (mag > longint'(SmallErr)) begin
      sum = longint'(shadow_integral) + e;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      shadow_integral = int'(sum);
    end else begin
      shadow_integral = 0;
    end
    // zero crossing also clears it
    if ((shadow_prev_err > 0 && e < 0) || (shadow_prev_err < 0 && e > 0))
      shadow_integral = 0;

    acc = longint'(shadow_kp) * e + longint'(shadow_ki) * longint'(shadow_integral)
        + longint'(shadow_kd) * (e - longint'(shadow_prev_err));
    w = (acc + longint'(HalfLsb)) >>> 12;   // round half up, floor
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    shadow_prev_err = err;

    v = shadow_vnom;
    if (!shadow_collision) begin
      if (mag > longint'(LargeErr)) v = (v * ScaleLarge + HalfLsb) >> 12;
    end else begin
      v = (v * ScaleColl + HalfLsb) >> 12;
    end
    if (nofree) begin
      v = 0;
      if (((w < 0) ? -w : w) <= longint'(WeakTurn)) w = longint'(EscapeTurn);
    end
    if (!shadow_power) begin
      v = 0;
      w = 0;
    end
    cmd.speed = v[SpeedW-1:0];
    cmd.turn  = w[TurnW-1:0];
    pending_cmds.push_back(cmd);
  endtask

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  function automatic int pick_len();
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic int pick_gap();
    if (gap_pct == 0 || $urandom_range(99) >= gap_pct) return 0;
    return pick_len();
  endfunction

  // Heading error biased to the thresholds and the extremes
  function automatic logic signed [ErrW-1:0] pick_heading();
    int m;
    case ($urandom_range(9))
      0, 1, 2: m = int'($urandom_range(65535)) - 32768;
      3:       m = int'(SmallErr) - 1 + int'($urandom_range(2));
      4:       m = int'(LargeErr) - 1 + int'($urandom_range(2));
      5:       m = int'($urandom_range(800)) - 400;
      6:       m = $urandom_range(1) ? 32767 : -32768;
      default: m = int'($urandom_range(12000)) - 6000;
    endcase
    if ($urandom_range(1) && m != -32768) m = -m;
    return ErrW'(m);
  endfunction

  function automatic logic [GainW-1:0] pick_gain(input int typical);
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return GainW'($urandom);
      default: return GainW'($urandom_range(typical));
    endcase
  endfunction

  function automatic logic [SpeedW-1:0] pick_speed();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      default: return SpeedW'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Beat driver, register writes and drain
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic signed [ErrW-1:0] err, input logic front,
                           input logic nofree, input logic ready);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    heading_error <= err;
    front_blocked <= front;
    all_blocked   <= nofree;
    scan_ready    <= ready;
    do @(posedge clk); while (!in_ready);
    predict_motion(err, front, nofree, ready);
    n_ticks++;
  endtask

  task automatic send_random_tick();
    send_tick(pick_heading(), $urandom_range(99) < 30, $urandom_range(99) < 20,
              $urandom_range(99) < 88);
  endtask

  // Block must be idle: no input beat and every command back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
    case (idx)
      REG_MOTION_EN:     shadow_power = val[0];
      REG_GAIN_P:        shadow_kp    = val[GainW-1:0];
      REG_GAIN_I:        shadow_ki    = val[GainW-1:0];
      REG_GAIN_D:        shadow_kd    = val[GainW-1:0];
      REG_NOMINAL_SPEED: shadow_vnom  = val[SpeedW-1:0];
      default: ;   // unmapped index, block ignores it
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= pick_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    motion_cmd_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected beat speed=%0d turn=%0d",
                                  linear_speed, turn_rate));
      end else begin
        want = pending_cmds.pop_front();
        n_checked++;
        if (linear_speed !== want.speed)
          report_mismatch($sformatf("linear_speed %0d, want %0d", linear_speed, want.speed));
        if (turn_rate !== want.turn)
          report_mismatch($sformatf("turn_rate %0d, want %0d", turn_rate,
                                    $signed(want.turn)));
      end
    end
  end

  // Watchdog: no beat on either side for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d commands owed",
               IdleLimit, pending_cmds.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Power is off after reset: commands are zero but the PID state still moves,
  // even on ticks without scan data. Then power on with the reset gains.
  task automatic test_reset_defaults();
    gap_pct   = 0;
    stall_pct = 0;
    send_tick(16'sd5000, 1'b1, 1'b0, 1'b0);
    send_tick(16'sd6000, 1'b0, 1'b1, 1'b1);
    send_tick(-16'sd300, 1'b0, 1'b0, 1'b1);
    drain();
    write_reg(REG_MOTION_EN, 16'd1);
    send_tick(16'sd2000, 1'b0, 1'b0, 1'b1);
    send_tick(16'sd2500, 1'b0, 1'b0, 1'b1);
    drain();
  endtask

  // Thresholds, extremes, collision scaling, escape turn, skipped ticks, unmapped indexes
  task automatic test_directed();
    gap_pct   = 20;
    stall_pct = 20;
    write_reg(REG_GAIN_I, 16'd64);
    send_tick(16'sd0, 1'b0, 1'b0, 1'b1);
    send_tick(16'sd32767, 1'b0, 1'b0, 1'b1);       // turn saturates high, speed x0.4
    send_tick(-16'sd32768, 1'b0, 1'b0, 1'b1);      // zero crossing, saturates low
    send_tick(16'sd409, 1'b0, 1'b0, 1'b1);         // small edge
    send_tick(16'sd410, 1'b0, 1'b0, 1'b1);
    send_tick(-16'sd409, 1'b0, 1'b0, 1'b1);
    send_tick(-16'sd410, 1'b0, 1'b0, 1'b1);
    send_tick(-16'sd4289, 1'b0, 1'b0, 1'b1);       // large-error edge
    send_tick(-16'sd4290, 1'b0, 1'b0, 1'b1);
    send_tick(16'sd4289, 1'b0, 1'b0, 1'b1);
    send_tick(16'sd4290, 1'b0, 1'b0, 1'b1);
    send_tick(16'sd1000, 1'b1, 1'b0, 1'b1);        // collision mode, speed x0.1
    send_tick(16'sd9000, 1'b1, 1'b0, 1'b1);        // collision beats large error
    send_tick(16'sd9000, 1'b1, 1'b1, 1'b1);        // boxed in, strong turn kept
    send_tick(16'sd0, 1'b0, 1'b1, 1'b1);           // boxed in, derivative kick keeps the turn strong
    send_tick(16'sd7000, 1'b1, 1'b0, 1'b0);        // no scan: swallowed
    send_tick(-16'sd7000, 1'b0, 1'b1, 1'b0);
    send_tick(16'sd7000, 1'b0, 1'b0, 1'b1);
    send_tick(16'sd7000, 1'b0, 1'b0, 1'b1);
    drain();
    // unmapped indexes must leave everything alone
    for (int u = int'(REG_NOMINAL_SPEED) + 1; u < (1 << CfgIndexW); u++)
      write_reg(CfgIndexW'(u), CfgDataW'($urandom));
    send_tick(16'sd3000, 1'b0, 1'b0, 1'b1);
    send_tick(-16'sd600, 1'b1, 1'b1, 1'b1);
    drain();
  endtask

  // All gains at full scale, then all at zero; speed at both ends
  task automatic test_gain_extremes();
    gap_pct   = 30;
    stall_pct = 30;
    write_reg(REG_GAIN_P, '1);
    write_reg(REG_GAIN_I, '1);
    write_reg(REG_GAIN_D, '1);
    write_reg(REG_NOMINAL_SPEED, CfgDataW'({SpeedW{1'b1}}));
    send_tick(16'sd32767, 1'b0, 1'b0, 1'b1);
    send_tick(-16'sd32768, 1'b0, 1'b0, 1'b1);
    repeat (18) send_random_tick();
    drain();
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I, '0);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_NOMINAL_SPEED, '0);
    repeat (12) send_random_tick();
    drain();
  endtask

  // Power dropped mid-run: zero commands, state keeps tracking
  task automatic test_power_cycle();
    gap_pct   = 10;
    stall_pct = 10;
    write_reg(REG_GAIN_P, 16'd6144);
    write_reg(REG_GAIN_I, 16'd200);
    write_reg(REG_GAIN_D, 16'd2048);
    write_reg(REG_NOMINAL_SPEED, 16'd4915);
    repeat (5) send_random_tick();
    drain();
    write_reg(REG_MOTION_EN, 16'd0);
    repeat (15) send_random_tick();
    drain();
    write_reg(REG_MOTION_EN, 16'd1);
    repeat (10) send_random_tick();
    drain();
  endtask

  // Random phases with their own settings, idling profile set per phase; the drain
  // between phases leaves the sender waiting for every command to come back
  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MOTION_EN, (ph == 3) ? 16'd0 : 16'd1);
      write_reg(REG_GAIN_P, pick_gain(12288));
      write_reg(REG_GAIN_I, pick_gain(256));
      write_reg(REG_GAIN_D, pick_gain(4096));
      write_reg(REG_NOMINAL_SPEED, CfgDataW'(pick_speed()));
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end   // flat out
        5:       begin gap_pct = 60; stall_pct = 60; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      repeat (120) send_random_tick();
      drain();
    end
  endtask

  initial begin
    shadow_power     = 1'b0;
    shadow_kp        = GainPReset;
    shadow_ki        = GainIReset;
    shadow_kd        = GainDReset;
    shadow_vnom      = NominalReset;
    shadow_collision = 1'b0;
    shadow_prev_err  = '0;
    shadow_integral  = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_gain_extremes();
    test_power_cycle();
    test_random_phases();

    drain();
    if (pending_cmds.size() != 0)
      report_mismatch($sformatf("%0d commands never arrived", pending_cmds.size()));
    $display("covered %0d ticks (%0d swallowed without scan data), %0d commands checked",
             n_ticks, n_skipped, n_checked);
    $display("%0d register writes incl. unmapped, gains and speed at both ends, %0d errors",
             n_writes, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/spcm_pkg.sv
design/steering_pid_with_collision_mode_unit.sv
verif/tb_steering_pid_with_collision_mode_unit.sv
